// ===== rtl/rstg_pkg.sv =====
`timescale 1ns / 1ps

package rstg_pkg;

	localparam int SINE_TABLE_BITS = 8;
	localparam int PHASE_BITS      = 24;
	localparam int INDEX_BITS      = 16;

	localparam int SINE_SIZE    = 1 << SINE_TABLE_BITS;
	localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
	localparam int LEN_BITS     = 16;
	localparam int CMP_BITS     = ((INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS) + 1;
	localparam int STEP_BITS    = 24;
	localparam int RECIP_BITS   = 17;
	localparam int CFG_BITS     = 24;
	localparam int ADDR_BITS    = 3;
	localparam int OPER_BITS    = 18;
	localparam int PROD_BITS    = 2 * OPER_BITS;

	localparam logic [RECIP_BITS-1:0] GAIN_ONE = RECIP_BITS'(65536);
	localparam logic [7:0]            SILENCE  = 8'd127;

	typedef enum logic [ADDR_BITS-1:0] {
		REG_PHASE_STEP  = 3'd0,
		REG_TONE_LEN    = 3'd1,
		REG_TOTAL_LEN   = 3'd2,
		REG_RAMP_LEN    = 3'd3,
		REG_RAMP_RECIP  = 3'd4
	} reg_addr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GAIN,
		ST_PROD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic gain;
		logic prod;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	typedef logic signed [15:0] sine_lut_t [SINE_SIZE];

	// Q1.15 sine, quarter wave by a degree-9 odd polynomial in Q30
	function automatic sine_lut_t build_sine();
		sine_lut_t   lut;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] p;
		logic [63:0] v;
		int          quad;
		int          r;
		int          m;
		for (int k = 0; k < SINE_SIZE; k++) begin
			quad = (k >> QUARTER_BITS) & 3;
			r    = k & ((1 << QUARTER_BITS) - 1);
			m    = ((quad & 1) != 0) ? ((1 << QUARTER_BITS) - r) : r;
			t    = 64'(m) << (30 - QUARTER_BITS);
			t2   = (t * t) >> 30;
			p    = 64'd172271;
			p    = 64'd5027044 - ((t2 * p) >> 30);
			p    = 64'd85569278 - ((t2 * p) >> 30);
			p    = 64'd693598671 - ((t2 * p) >> 30);
			p    = 64'd1686629713 - ((t2 * p) >> 30);
			v    = (t * p) >> 30;
			v    = (v * 64'd32767 + (64'd1 << 29)) >> 30;
			if (v > 64'd32767)
				v = 64'd32767;
			lut[k] = (quad >= 2) ? -$signed(16'(v)) : $signed(16'(v));
		end
		return lut;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine();

endpackage

// ===== rtl/ramped_sine_tone_generator.sv =====
`timescale 1ns / 1ps

// Ramped sine tone generator. Every input transfer yields exactly one output
// transfer carrying an unsigned 8-bit sample (127 is silence); s_tdata[0] set
// restarts the tone at sample 0. Each item passes through accept, gain
// multiply, sine times gain multiply, and output load, all sequenced by one
// controller that shares a single 18x18 multiplier. The next item is taken
// while a finished sample still waits in the output register. Registers
// (cfg_addr): 0 phase step (Q24), 1 tone length, 2 total length, 3 ramp
// length, 4 ramp reciprocal (Q16 of 65536 / ramp length). Write them only
// while no item is in flight.
module ramped_sine_tone_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rstg_pkg::ADDR_BITS-1:0] cfg_addr,
	input  logic [rstg_pkg::CFG_BITS-1:0]  cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [0] restart, [7:1] zero
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] sample
	output logic                           m_tlast,
	output logic                           m_tuser    // [0] done_res
);
	import rstg_pkg::*;

	cmd_t    cmd;
	status_t status;

	rstg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rstg_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.restart    (s_tdata[0]),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_sample (m_tdata),
		.out_last   (m_tlast),
		.out_done   (m_tuser)
	);

endmodule

// ===== rtl/rstg_ctrl.sv =====
`timescale 1ns / 1ps

module rstg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  rstg_pkg::status_t status,
	output rstg_pkg::cmd_t    cmd
);
	import rstg_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_GAIN;
				end
			end
			ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/rstg_datapath.sv =====
`timescale 1ns / 1ps

module rstg_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rstg_pkg::ADDR_BITS-1:0]  cfg_addr,
	input  logic [rstg_pkg::CFG_BITS-1:0]   cfg_data,
	input  logic                            restart,
	input  rstg_pkg::cmd_t                  cmd,
	output rstg_pkg::status_t               status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_sample,
	output logic                            out_last,
	output logic                            out_done
);
	import rstg_pkg::*;

	logic [STEP_BITS-1:0]  phase_step_q;
	logic [LEN_BITS-1:0]   tone_len_q;
	logic [LEN_BITS-1:0]   total_len_q;
	logic [LEN_BITS-1:0]   ramp_len_q;
	logic [RECIP_BITS-1:0] ramp_recip_q;

	logic [INDEX_BITS-1:0] index_q;
	logic [PHASE_BITS-1:0] phase_q;

	logic                  done_s1;
	logic                  last_s1;
	logic                  tone_s1;
	logic                  unity_s1;
	logic signed [15:0]    sine_s1;
	logic signed [PROD_BITS-1:0] mul_q;

	logic                  out_valid_q;
	logic [7:0]            sample_q;
	logic                  last_q;
	logic                  done_q;

	logic [CMP_BITS-1:0]   idx_w;
	logic [CMP_BITS-1:0]   tone_w;
	logic [CMP_BITS-1:0]   total_w;
	logic                  is_done;
	logic                  fade_out;
	logic                  fade_in;
	logic [LEN_BITS-1:0]   factor;
	logic [RECIP_BITS-1:0] gain;
	logic signed [OPER_BITS-1:0] oper_a;
	logic signed [OPER_BITS-1:0] oper_b;
	logic [31:0]           biased;
	logic [39:0]           scaled;

	assign idx_w    = CMP_BITS'(index_q);
	assign tone_w   = CMP_BITS'(tone_len_q);
	assign total_w  = CMP_BITS'(total_len_q);
	assign is_done  = idx_w >= total_w;
	assign fade_out = (idx_w + CMP_BITS'(ramp_len_q)) >= tone_w;
	assign fade_in  = idx_w < CMP_BITS'(ramp_len_q);
	assign factor   = fade_out ? LEN_BITS'(tone_w - idx_w) : LEN_BITS'(idx_w);

	assign gain = (unity_s1 || (mul_q[PROD_BITS-2:0] > (PROD_BITS-1)'(GAIN_ONE))) ?
		GAIN_ONE : mul_q[RECIP_BITS-1:0];

	always_comb begin
		if (cmd.prod) begin
			oper_a = $signed({1'b0, gain});
			oper_b = OPER_BITS'(sine_s1);
		end else begin
			oper_a = $signed({1'b0, ramp_recip_q});
			oper_b = $signed({2'b00, factor});
		end
	end

	// 255 * (G*S + 2^31) >> 32
	assign biased = {~mul_q[31], mul_q[30:0]};
	assign scaled = {biased, 8'h00} - {8'h00, biased};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			tone_len_q   <= '0;
			total_len_q  <= '0;
			ramp_len_q   <= '0;
			ramp_recip_q <= '0;
			index_q      <= '0;
			phase_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_PHASE_STEP: phase_step_q <= cfg_data[STEP_BITS-1:0];
					REG_TONE_LEN:   tone_len_q   <= cfg_data[LEN_BITS-1:0];
					REG_TOTAL_LEN:  total_len_q  <= cfg_data[LEN_BITS-1:0];
					REG_RAMP_LEN:   ramp_len_q   <= cfg_data[LEN_BITS-1:0];
					REG_RAMP_RECIP: ramp_recip_q <= cfg_data[RECIP_BITS-1:0];
					default: ;
				endcase
			end
			if (cmd.load && restart) begin
				index_q <= '0;
				phase_q <= '0;
			end else if (cmd.gain && !is_done && (index_q != '1)) begin
				index_q <= index_q + 1'b1;
				phase_q <= phase_q + PHASE_BITS'(phase_step_q);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gain) begin
			done_s1  <= is_done;
			last_s1  <= !is_done && ((idx_w + 1'b1) == total_w);
			tone_s1  <= idx_w < tone_w;
			unity_s1 <= !fade_out && !fade_in;
			sine_s1  <= SINE_LUT[phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS]];
		end
		if (cmd.gain || cmd.prod) begin
			mul_q <= oper_a * oper_b;
		end
		if (cmd.finish) begin
			sample_q <= (!done_s1 && tone_s1) ? scaled[39:32] : SILENCE;
			last_q   <= last_s1;
			done_q   <= done_s1;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_sample      = sample_q;
	assign out_last        = last_q;
	assign out_done        = done_q;

endmodule

// ===== rtl/rstg_checker.sv =====
`timescale 1ns / 1ps

module rstg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);
	import rstg_pkg::*;

	// one item at a time on the input side
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == SILENCE) && !m_tlast)
		else $error("done sample not silent or marked last");

	// level never reaches full scale
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != 8'hff)
		else $error("sample out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output transfer changed");

endmodule

bind ramped_sine_tone_generator rstg_checker u_rstg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
